/* hw/rtl/rmcc_pkg.sv */
// Package for the RMAP command checker: transaction types, status codes,
// register indexes, reset values and the RMAP CRC-8 step. No dependencies.
package rmcc_pkg;

  // Fixed protocol identifier that byte 1 of a command must carry
  localparam logic [7:0] PROTOCOL_ID = 8'd1;

  // Byte position counter width and its saturation value
  localparam int unsigned POS_W = 25;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Fixed header positions ahead of the source path
  localparam logic [POS_W-1:0] POS_TARGET   = 25'd0;
  localparam logic [POS_W-1:0] POS_PROTOCOL = 25'd1;
  localparam logic [POS_W-1:0] POS_INSTR    = 25'd2;
  localparam logic [POS_W-1:0] POS_KEY      = 25'd3;

  // Header offsets after the source path (add 4 * path words)
  localparam logic [POS_W-1:0] OFS_INITIATOR = 25'd4;
  localparam logic [POS_W-1:0] OFS_ADDR_LO   = 25'd7;
  localparam logic [POS_W-1:0] OFS_ADDR_HI   = 25'd11;
  localparam logic [POS_W-1:0] OFS_LEN_LO    = 25'd12;
  localparam logic [POS_W-1:0] OFS_LEN_HI    = 25'd14;
  localparam logic [POS_W-1:0] OFS_HDR_CRC   = 25'd15;

  // Packet lengths used by the length checks
  localparam logic [POS_W:0] READ_CMD_LEN = 26'd16;
  localparam logic [POS_W:0] MIN_HDR_LEN  = 26'd16;
  localparam logic [POS_W:0] WR_OVERHEAD  = 26'd17;

  // Configuration register indexes
  localparam logic [7:0] CFG_TARGET    = 8'd0;
  localparam logic [7:0] CFG_KEY       = 8'd1;
  localparam logic [7:0] CFG_INITIATOR = 8'd2;
  localparam logic [7:0] CFG_OPCODE    = 8'd3;
  localparam logic [7:0] CFG_MEM_ADDR  = 8'd4;

  // Configuration reset values
  localparam logic [7:0]  RST_TARGET    = 8'd144;
  localparam logic [7:0]  RST_KEY       = 8'd111;
  localparam logic [7:0]  RST_INITIATOR = 8'd145;
  localparam logic [7:0]  RST_OPCODE    = 8'd96;
  localparam logic [39:0] RST_MEM_ADDR  = 40'd444691369455;

  // Instruction bit that marks a write command
  localparam int unsigned OPCODE_WRITE_BIT = 5;

  // Verdict status codes, in priority order
  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_LENGTH    = 4'd1,
    ST_TARGET    = 4'd2,
    ST_PROTOCOL  = 4'd3,
    ST_HDR_CRC   = 4'd4,
    ST_OPCODE    = 4'd5,
    ST_KEY       = 4'd6,
    ST_MEM_ADDR  = 4'd7,
    ST_INITIATOR = 4'd8,
    ST_DATA_LEN  = 4'd9,
    ST_DATA_CRC  = 4'd10
  } status_t;

  // Input transaction: one packet byte
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_packet;
  } pkt_t;

  // Result transaction: forwarded data byte or verdict
  typedef struct packed {
    logic        is_verdict;
    logic [7:0]  payload_byte;
    logic [3:0]  check_status;
    logic [23:0] payload_length;
  } res_t;

  // Channel configuration seen by the checking logic
  typedef struct packed {
    logic [7:0]  target;
    logic [7:0]  key;
    logic [7:0]  initiator;
    logic [7:0]  opcode;
    logic [39:0] mem_address;
  } cfg_t;

  // Sticky header field mismatches of the current packet
  typedef struct packed {
    logic target;
    logic protocol;
    logic hdr_crc;
    logic opcode;
    logic key;
    logic initiator;
  } mismatch_t;

  // RMAP CRC-8 of one byte: reflected x^8+x^2+x+1, eight shift steps
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 8'hE0) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* hw/rtl/rmap_command_checker_top.sv */
// Top level of the RMAP command checker: configuration registers, input
// register, result register and the rmcc_core step. Depends on rmcc_pkg.
//
// Usage:
//   pkt channel (pkt_valid / pkt_stall / pkt) carries one command byte per
//   transaction with an end-of-packet mark. res channel (res_valid /
//   res_stall / res) returns forwarded write data bytes and, for the last
//   byte of each packet, one verdict with the status and data length.
//   The cfg channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the
//   expected target, key, initiator, opcode and 40-bit memory address; it
//   is always ready and must only be used while no packet is in flight.
// Timing:
//   One byte per cycle sustained while res_stall does not hold a valid
//   result. A byte is registered on acceptance and its result is loaded
//   into the result register once that register can advance; the CRC
//   step and field compares are combinational between the two registers.
//   While a valid result is stalled the result register holds, the input
//   register keeps one byte and pkt_stall rises once that byte is waiting.
//   Synchronous reset empties both registers, clears the packet state and
//   loads the configuration reset values.
module rmap_command_checker_top (
  input  logic           clk,
  input  logic           rst,
  // Command byte channel
  input  logic           pkt_valid,
  output logic           pkt_stall,
  input  rmcc_pkg::pkt_t pkt,
  // Result channel
  output logic           res_valid,
  input  logic           res_stall,
  output rmcc_pkg::res_t res,
  // Configuration write channel
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [7:0]     cfg_index,
  input  logic [39:0]    cfg_data
);
  import rmcc_pkg::*;

  cfg_t  cfg;
  logic  iq_valid;
  pkt_t  iq;
  logic  advance;
  logic  step;
  logic  hit;
  res_t  result;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target      <= RST_TARGET;
      cfg.key         <= RST_KEY;
      cfg.initiator   <= RST_INITIATOR;
      cfg.opcode      <= RST_OPCODE;
      cfg.mem_address <= RST_MEM_ADDR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TARGET:    cfg.target      <= cfg_data[7:0];
        CFG_KEY:       cfg.key         <= cfg_data[7:0];
        CFG_INITIATOR: cfg.initiator   <= cfg_data[7:0];
        CFG_OPCODE:    cfg.opcode      <= cfg_data[7:0];
        CFG_MEM_ADDR:  cfg.mem_address <= cfg_data;
        default: ;
      endcase
    end
  end

  // The step runs whenever the result register can take its outcome
  assign advance   = !res_valid || !res_stall;
  assign step      = iq_valid && advance;
  assign pkt_stall = iq_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      iq_valid <= 1'b0;
    end else if (pkt_valid && !pkt_stall) begin
      iq_valid <= 1'b1;
    end else if (advance) begin
      iq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_valid && !pkt_stall) begin
      iq <= pkt;
    end
  end

  rmcc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (iq),
    .cfg    (cfg),
    .hit    (hit),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= step && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= result;
    end
  end

`ifndef ASSERT_OFF
  // Input side only stalls when a byte is actually waiting
  a_stall_has_byte: assert property (@(posedge clk) disable iff (rst)
    pkt_stall |-> iq_valid)
    else $error("pkt_stall without a buffered byte");

  // A forwarded data byte carries no status and no length
  a_fwd_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.is_verdict) |->
      (res.check_status == ST_OK && res.payload_length == 24'd0))
    else $error("forwarded byte with status or length");

  // A nonzero data length is only reported on a good write verdict
  a_len_on_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.is_verdict && res.payload_length != 24'd0) |->
      (res.check_status == ST_OK && cfg.opcode[OPCODE_WRITE_BIT]))
    else $error("data length on failed or read verdict");

  // A byte that produces a result is in the result register next cycle
  a_step_lands: assert property (@(posedge clk) disable iff (rst)
    (step && hit) |=> res_valid)
    else $error("result of a processed byte was lost");
`endif

endmodule

/* hw/rtl/rmcc_core.sv */
// Per-packet checking state and the byte step of the RMAP command
// checker. Depends on rmcc_pkg.
module rmcc_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  rmcc_pkg::pkt_t item,
  input  rmcc_pkg::cfg_t cfg,
  output logic           hit,
  output rmcc_pkg::res_t result
);
  import rmcc_pkg::*;

  // Packet state
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [1:0]       path_words, path_words_next;
  logic [7:0]       running_crc, running_crc_next;
  logic [39:0]      captured_address, captured_address_next;
  logic [23:0]      captured_length, captured_length_next;
  mismatch_t        flags, flags_next;

  logic [7:0]       b;
  logic             eop;
  logic             wr;
  logic [POS_W-1:0] n;
  logic             at_init, in_addr, in_len, at_hcrc, in_data;
  logic [POS_W:0]   len;
  logic             len_bad, dlen_bad, dcrc_bad;
  status_t          st;

  assign b   = item.rx_byte;
  assign eop = item.end_of_packet;
  assign wr  = cfg.opcode[OPCODE_WRITE_BIT];

  // Source path length, taken from the instruction byte as it passes
  always_comb begin
    path_words_next = (byte_position == POS_INSTR) ? b[1:0] : path_words;
    n = {{(POS_W-4){1'b0}}, path_words_next, 2'b00};
  end

  // Header region decode after the source path
  always_comb begin
    at_init = byte_position == OFS_INITIATOR + n;
    in_addr = (byte_position >= OFS_ADDR_LO + n) && (byte_position <= OFS_ADDR_HI + n);
    in_len  = (byte_position >= OFS_LEN_LO + n) && (byte_position <= OFS_LEN_HI + n);
    at_hcrc = byte_position == OFS_HDR_CRC + n;
    in_data = byte_position > OFS_HDR_CRC + n;
  end

  // Field checks, captures and CRC
  always_comb begin
    flags_next            = flags;
    captured_address_next = captured_address;
    captured_length_next  = captured_length;
    running_crc_next      = crc8_step(running_crc, b);
    dcrc_bad              = 1'b0;
    case (byte_position)
      POS_TARGET:   if (b != cfg.target) flags_next.target = 1'b1;
      POS_PROTOCOL: if (b != PROTOCOL_ID) flags_next.protocol = 1'b1;
      POS_INSTR:    if ({b[7:2], 2'b00} != cfg.opcode) flags_next.opcode = 1'b1;
      POS_KEY:      if (b != cfg.key) flags_next.key = 1'b1;
      default: begin
        if (at_init) begin
          if (b != cfg.initiator) flags_next.initiator = 1'b1;
        end else if (in_addr) begin
          captured_address_next = {captured_address[31:0], b};
        end else if (in_len) begin
          captured_length_next = {captured_length[15:0], b};
        end else if (at_hcrc) begin
          if (b != running_crc) flags_next.hdr_crc = 1'b1;
          running_crc_next = 8'h00;
        end else if (in_data && eop) begin
          dcrc_bad = b != running_crc;
        end
      end
    endcase
  end

  // Verdict, first failing check wins
  always_comb begin
    len      = {1'b0, byte_position} + {{POS_W{1'b0}}, 1'b1};
    len_bad  = (!wr && (len != READ_CMD_LEN)) || (len < MIN_HDR_LEN + {1'b0, n});
    dlen_bad = wr && (len != WR_OVERHEAD + {1'b0, n} + {{(POS_W-23){1'b0}}, captured_length_next});
    if (len_bad)                                       st = ST_LENGTH;
    else if (flags_next.target)                        st = ST_TARGET;
    else if (flags_next.protocol)                      st = ST_PROTOCOL;
    else if (flags_next.hdr_crc)                       st = ST_HDR_CRC;
    else if (flags_next.opcode)                        st = ST_OPCODE;
    else if (flags_next.key)                           st = ST_KEY;
    else if (captured_address_next != cfg.mem_address) st = ST_MEM_ADDR;
    else if (flags_next.initiator)                     st = ST_INITIATOR;
    else if (dlen_bad)                                 st = ST_DATA_LEN;
    else if (wr && dcrc_bad)                           st = ST_DATA_CRC;
    else                                               st = ST_OK;
  end

  // Result of this byte: verdict on end of packet, data forward on write
  always_comb begin
    result = '0;
    hit    = 1'b0;
    if (eop) begin
      hit                   = 1'b1;
      result.is_verdict     = 1'b1;
      result.check_status   = st;
      result.payload_length = (st == ST_OK && wr) ? captured_length_next : 24'd0;
    end else if (in_data && wr) begin
      hit                 = 1'b1;
      result.payload_byte = b;
    end
  end

  // Saturating byte counter, cleared at end of packet
  always_comb begin
    if (eop) begin
      byte_position_next = '0;
    end else if (byte_position == POS_MAX) begin
      byte_position_next = byte_position;
    end else begin
      byte_position_next = byte_position + {{(POS_W-1){1'b0}}, 1'b1};
    end
  end

  // State update; everything clears after a verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      path_words       <= '0;
      running_crc      <= '0;
      captured_address <= '0;
      captured_length  <= '0;
      flags            <= '0;
    end else if (step) begin
      byte_position <= byte_position_next;
      if (eop) begin
        path_words       <= '0;
        running_crc      <= '0;
        captured_address <= '0;
        captured_length  <= '0;
        flags            <= '0;
      end else begin
        path_words       <= path_words_next;
        running_crc      <= running_crc_next;
        captured_address <= captured_address_next;
        captured_length  <= captured_length_next;
        flags            <= flags_next;
      end
    end
  end

endmodule
